[rtl/core/tile_matrix_multiply_accumulate_macros.svh]
// Assertion macros for the tile multiply-accumulate block.
// Included by the top level; no other dependencies.
`ifndef TILE_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define TILE_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`ifndef SYNTHESIS
`define TMMA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define TMMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TMMA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TMMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/tmma_pkg.sv]
// Shared constants and types for the tile multiply-accumulate block.
// No dependencies.
package tmma_pkg;
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_MAX_ROUNDS = 16;
  localparam int DEF_ELEM_WIDTH = 16;
  localparam int ACC_W          = 48;
  localparam int IDX_MAX_W      = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 2'd1;

  // token moving along the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 is_b;   // 1: B element for column idx, 0: A element of row idx
    logic [IDX_MAX_W-1:0] idx;
  } tok_t;
endpackage

[rtl/core/tmma_cell.sv]
// One column cell of the multiply chain: holds a B element and row partial sums.
// Depends on tmma_pkg.
module tmma_cell import tmma_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int SUM_W      = 2 * DEF_ELEM_WIDTH + 3,
  parameter int COL        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  tok_t                  tok_in,
  input  logic [ELEM_WIDTH-1:0] data_in,
  input  logic [IDX_MAX_W-1:0]  rd_row,
  input  logic                  clr,
  output tok_t                  tok_out,
  output logic [ELEM_WIDTH-1:0] data_out,
  output logic [SUM_W-1:0]      sum
);
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [ELEM_WIDTH-1:0]          breg;
  logic                           p_valid;
  logic [IDX_W-1:0]               p_row;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic [SUM_W-1:0]               s [MAX_DIM];
  logic [IDX_W-1:0]               s_addr;

  assign s_addr = p_valid ? p_row : rd_row[IDX_W-1:0];
  assign sum    = s[s_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      p_valid <= 1'b0;
    end else begin
      tok_out <= tok_in;
      p_valid <= tok_in.valid && !tok_in.is_b && active;
    end
    data_out <= data_in;
    p_row    <= tok_in.idx[IDX_W-1:0];
    prod     <= $signed(data_in) * $signed(breg);
    if (tok_in.valid && tok_in.is_b && tok_in.idx[IDX_W-1:0] == IDX_W'(COL)) begin
      breg <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        s[i] <= '0;
      end
    end else if (p_valid) begin
      s[s_addr] <= s[s_addr] + SUM_W'(prod);
    end else if (clr) begin
      s[s_addr] <= '0;
    end
  end
endmodule

[rtl/core/tile_matrix_multiply_accumulate.sv]
// Tile multiply-accumulate block: tile memories, sequencer, cell chain, accumulator.
// Depends on tmma_pkg, tmma_cell and the macros header.
//
// Usage: s_tdata carries {b_element, a_element}, one pair per transfer, row-major,
// n*n transfers per round (n = tile_size). After each round the tile product A*B
// is added into the accumulator; after round_count rounds the accumulator goes
// out on m_tdata row by row, m_tlast on the final element, and is cleared.
// Configuration: cfg_index 0 = tile_size, 1 = round_count, cfg_ready always high.
// Each round runs tile loading (one transfer per cycle while s_tvalid is high),
// chain issue, a drain of the chain of MAX_DIM cells, and accumulator write-back
// of the n*n elements through the single accumulator port. Emission handles
// one element at a time: registered read, load, transfer. s_tready is low
// outside loading. Reset (rst, synchronous) clears the accumulator, counters
// and the sequencer and restores tile_size 8, round_count 2. A stalled receiver
// holds m_tdata and m_tlast stable and the block waits; nothing is dropped.
`include "tile_matrix_multiply_accumulate_macros.svh"
module tile_matrix_multiply_accumulate import tmma_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_ROUNDS = DEF_MAX_ROUNDS,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0]     s_tdata,   // a_element, b_element, pad
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ACC_W-1:0]                      m_tdata,   // c_element
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);
  localparam int TILE_N = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (TILE_N > 1) ? $clog2(TILE_N) : 1;
  localparam int POS_W  = $clog2(TILE_N + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int RND_W  = $clog2(MAX_ROUNDS + 1);
  localparam int SUM_W  = 2 * ELEM_WIDTH + $clog2(MAX_DIM);
  localparam int DRN_W  = $clog2(MAX_DIM + 4);

  typedef enum logic [7:0] {
    ST_LOAD      = 8'b0000_0001,
    ST_ISSUE     = 8'b0000_0010,
    ST_DRAIN     = 8'b0000_0100,
    ST_WB        = 8'b0000_1000,
    ST_WB_END    = 8'b0001_0000,
    ST_EMIT_RD   = 8'b0010_0000,
    ST_EMIT_LD   = 8'b0100_0000,
    ST_EMIT_WAIT = 8'b1000_0000
  } state_t;

  state_t state;

  logic [3:0]       tile_size;
  logic [4:0]       round_count;
  logic [DIM_W-1:0] n_eff;
  logic [RND_W-1:0] rnd_eff;
  logic [POS_W-1:0] cells;

  logic [ELEM_WIDTH-1:0] a_mem [TILE_N];
  logic [ELEM_WIDTH-1:0] b_mem [TILE_N];
  logic [ELEM_WIDTH-1:0] a_rd, b_rd;
  logic [ACC_W-1:0]      acc_mem [TILE_N];
  logic [TILE_N-1:0]     acc_vld;
  logic [ACC_W-1:0]      acc_rd;
  logic                  acc_rv;
  logic [ACC_W-1:0]      acc_val;
  logic [ADDR_W-1:0]     acc_raddr;

  logic [POS_W-1:0]  load_pos;
  logic [RND_W-1:0]  rounds_done;
  logic              phase_b;
  logic [IDX_W-1:0]  kk, jj;
  logic [ADDR_W-1:0] a_addr, b_addr;
  tok_t              pend;
  logic [DRN_W-1:0]  drain_cnt;
  logic [POS_W-1:0]  wi;
  logic [IDX_W-1:0]  wr, wc;
  logic              wb_v;
  logic [ADDR_W-1:0] wb_addr;
  logic [SUM_W-1:0]  wb_s;
  logic [POS_W-1:0]  ei;

  tok_t                  tok_in   [MAX_DIM];
  tok_t                  tok_out  [MAX_DIM];
  logic [ELEM_WIDTH-1:0] data_in  [MAX_DIM];
  logic [ELEM_WIDTH-1:0] data_out [MAX_DIM];
  logic [SUM_W-1:0]      cell_sum [MAX_DIM];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_LOAD);

  always_comb begin
    if (tile_size == 4'd0) begin
      n_eff = DIM_W'(1);
    end else if (32'(tile_size) > MAX_DIM) begin
      n_eff = DIM_W'(MAX_DIM);
    end else begin
      n_eff = DIM_W'(tile_size);
    end
    if (round_count == 5'd0) begin
      rnd_eff = RND_W'(1);
    end else if (32'(round_count) > MAX_ROUNDS) begin
      rnd_eff = RND_W'(MAX_ROUNDS);
    end else begin
      rnd_eff = RND_W'(round_count);
    end
  end
  assign cells = POS_W'(n_eff) * POS_W'(n_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size   <= 4'd8;
      round_count <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TILE_SIZE:   tile_size   <= cfg_data[3:0];
        CFG_ROUND_COUNT: round_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // tile memories
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_mem[load_pos[ADDR_W-1:0]] <= s_tdata[ELEM_WIDTH-1:0];
      b_mem[load_pos[ADDR_W-1:0]] <= s_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH];
    end
    a_rd <= a_mem[a_addr];
    b_rd <= b_mem[b_addr];
  end

  // accumulator memory
  assign acc_raddr = (state == ST_EMIT_RD) ? ei[ADDR_W-1:0] : wi[ADDR_W-1:0];
  assign acc_val   = acc_rv ? acc_rd : '0;

  always_ff @(posedge clk) begin
    acc_rd <= acc_mem[acc_raddr];
    acc_rv <= acc_vld[acc_raddr];
    if (wb_v) begin
      acc_mem[wb_addr] <= acc_val + ACC_W'($signed(wb_s));
    end else if (state == ST_EMIT_LD) begin
      acc_mem[ei[ADDR_W-1:0]] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (wb_v) begin
      acc_vld[wb_addr] <= 1'b1;
    end
  end

  // cell chain
  assign tok_in[0]  = pend;
  assign data_in[0] = pend.is_b ? b_rd : a_rd;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    if (c > 0) begin : g_link
      assign tok_in[c]  = tok_out[c-1];
      assign data_in[c] = data_out[c-1];
    end
    tmma_cell #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH),
      .SUM_W      (SUM_W),
      .COL        (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .active   (32'(c) < 32'(n_eff)),
      .tok_in   (tok_in[c]),
      .data_in  (data_in[c]),
      .rd_row   (IDX_MAX_W'(wr)),
      .clr      ((state == ST_WB) && (wc == IDX_W'(c))),
      .tok_out  (tok_out[c]),
      .data_out (data_out[c]),
      .sum      (cell_sum[c])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      load_pos    <= '0;
      rounds_done <= '0;
      pend        <= '0;
      wb_v        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      pend.valid <= 1'b0;
      wb_v       <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (load_pos + 1'b1 >= cells) begin
              load_pos <= '0;
              state    <= ST_ISSUE;
              phase_b  <= 1'b1;
              kk       <= '0;
              jj       <= '0;
              b_addr   <= '0;
            end else begin
              load_pos <= load_pos + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          pend.valid <= 1'b1;
          pend.is_b  <= phase_b;
          pend.idx   <= IDX_MAX_W'(jj);
          if (phase_b) begin
            b_addr <= b_addr + 1'b1;
            if (jj == IDX_W'(n_eff - 1'b1)) begin
              jj      <= '0;
              phase_b <= 1'b0;
              a_addr  <= ADDR_W'(kk);
            end else begin
              jj <= jj + 1'b1;
            end
          end else begin
            a_addr <= a_addr + ADDR_W'(n_eff);
            if (jj == IDX_W'(n_eff - 1'b1)) begin
              jj      <= '0;
              phase_b <= 1'b1;
              if (kk == IDX_W'(n_eff - 1'b1)) begin
                state     <= ST_DRAIN;
                drain_cnt <= '0;
              end else begin
                kk <= kk + 1'b1;
              end
            end else begin
              jj <= jj + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRN_W'(MAX_DIM + 3)) begin
            state <= ST_WB;
            wi    <= '0;
            wr    <= '0;
            wc    <= '0;
          end
        end
        ST_WB: begin
          wb_v    <= 1'b1;
          wb_addr <= wi[ADDR_W-1:0];
          wb_s    <= cell_sum[wc];
          wi      <= wi + 1'b1;
          if (wc == IDX_W'(n_eff - 1'b1)) begin
            wc <= '0;
            wr <= wr + 1'b1;
          end else begin
            wc <= wc + 1'b1;
          end
          if (wi + 1'b1 == cells) begin
            state <= ST_WB_END;
          end
        end
        ST_WB_END: begin
          if (rounds_done + 1'b1 >= rnd_eff) begin
            rounds_done <= '0;
            ei          <= '0;
            state       <= ST_EMIT_RD;
          end else begin
            rounds_done <= rounds_done + 1'b1;
            state       <= ST_LOAD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= acc_val;
          m_tlast  <= (ei + 1'b1 == cells);
          state    <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            ei       <= ei + 1'b1;
            state    <= m_tlast ? ST_LOAD : ST_EMIT_RD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  `TMMA_ASSERT_IMPLIES(a_no_load_during_emit, clk, rst, m_tvalid, !s_tready)
  `TMMA_ASSERT_NEXT(a_last_returns_to_load, clk, rst, m_tvalid && m_tready && m_tlast, state == ST_LOAD)
  `TMMA_ASSERT_IMPLIES(a_token_from_issue, clk, rst, pend.valid, $past(state == ST_ISSUE))
  `TMMA_ASSERT_IMPLIES(a_chain_quiet_outside_compute, clk, rst, tok_out[MAX_DIM-1].valid, state == ST_ISSUE || state == ST_DRAIN)
endmodule
